// ===== design/swrm_pkg.sv =====
// Shared types and constants of the stack with remove-minimum.
package swrm_pkg;

	localparam int KEY_W     = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_RMMIN = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_PUSH,
		DP_REJ_FULL,
		DP_REJ_EMPTY,
		DP_POP,
		DP_PEEK,
		DP_READ_OUT,
		DP_SCAN_START,
		DP_SCAN,
		DP_SHIFT
	} dp_op_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_full;
		logic scan_last;
		logic shift_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/swrm_in_if.sv =====
// Command channel: valid, ready and one command word.
interface swrm_in_if;
	import swrm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic signed [KEY_W-1:0] push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink (input valid, input cmd, input push_value, output ready);
endinterface

// ===== design/swrm_out_if.sv =====
// Result channel: valid, ready and one result word.
interface swrm_out_if;
	import swrm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] value;
	logic [STATUS_W-1:0]     status;
	logic [OCC_W-1:0]        occupancy;

	modport source (output valid, output value, output status, output occupancy, input ready);
	modport sink (input valid, input value, input status, input occupancy, output ready);
endinterface

// ===== design/swrm_ctrl.sv =====
// Controller state machine that sequences each command through the datapath.
module swrm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [swrm_pkg::CMD_W-1:0]    in_cmd,
	output logic                          in_ready,
	input  swrm_pkg::dp_stat_t            stat,
	output swrm_pkg::dp_op_t              op
);
	import swrm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		op        = DP_NOP;
		state_nxt = state_q;
		in_ready  = (state_q == S_IDLE) && stat.out_free;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (cmd_t'(in_cmd))
						CMD_PUSH: begin
							op = stat.fill_full ? DP_REJ_FULL : DP_PUSH;
						end
						CMD_POP: begin
							if (stat.fill_zero) begin
								op = DP_REJ_EMPTY;
							end else begin
								op        = DP_POP;
								state_nxt = S_READ;
							end
						end
						CMD_PEEK: begin
							if (stat.fill_zero) begin
								op = DP_REJ_EMPTY;
							end else begin
								op        = DP_PEEK;
								state_nxt = S_READ;
							end
						end
						CMD_RMMIN: begin
							if (stat.fill_zero) begin
								op = DP_REJ_EMPTY;
							end else begin
								op        = DP_SCAN_START;
								state_nxt = S_SCAN;
							end
						end
						default: op = DP_NOP;
					endcase
				end
			end
			S_READ: begin
				op        = DP_READ_OUT;
				state_nxt = S_IDLE;
			end
			S_SCAN: begin
				op = DP_SCAN;
				if (stat.scan_last) begin
					state_nxt = S_SHIFT;
				end
			end
			S_SHIFT: begin
				op = DP_SHIFT;
				if (stat.shift_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

// ===== design/swrm_dp.sv =====
// Datapath: key memory, fill count, minimum scan, compaction and result register.
module swrm_dp #(
	parameter int DEPTH = swrm_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swrm_pkg::dp_op_t                   op,
	input  logic signed [swrm_pkg::KEY_W-1:0]  push_value,
	output swrm_pkg::dp_stat_t                 stat,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [swrm_pkg::KEY_W-1:0]  out_value,
	output logic [swrm_pkg::STATUS_W-1:0]      out_status,
	output logic [swrm_pkg::OCC_W-1:0]         out_occupancy
);
	import swrm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0]        mem_q [DEPTH];
	logic [KEY_W-1:0]        rd_data_q;
	logic [CW-1:0]           fill_q;
	logic [KEY_W-1:0]        min_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           idx_q;
	logic [CW-1:0]           wptr_q;
	logic                    pend_q;
	logic                    out_valid_q;
	logic [KEY_W-1:0]        value_q;
	status_t                 status_q;
	logic [OCC_W-1:0]        occ_q;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [KEY_W-1:0]        wr_data;
	logic [CW-1:0]           fill_m1;
	logic [CW-1:0]           fill_p1;
	logic [AW-1:0]           top_addr;
	logic                    scan_take;
	logic [CW-1:0]           wptr_nxt;
	logic [CW:0]             shift_rd;
	logic                    shift_done;
	logic                    out_load;
	logic [KEY_W-1:0]        load_value;
	status_t                 load_status;
	logic [CW-1:0]           load_occ;

	assign fill_m1    = fill_q - CW'(1);
	assign fill_p1    = fill_q + CW'(1);
	assign top_addr   = fill_m1[AW-1:0];
	assign scan_take  = (idx_q == top_addr) || ($signed(rd_data_q) < $signed(min_q));
	assign wptr_nxt   = pend_q ? (wptr_q + CW'(1)) : wptr_q;
	assign shift_rd   = {1'b0, wptr_nxt} + (CW + 1)'(1);
	assign shift_done = shift_rd >= {1'b0, fill_q};

	assign stat.fill_zero  = (fill_q == '0);
	assign stat.fill_full  = (fill_q == CW'(DEPTH));
	assign stat.scan_last  = (idx_q == '0);
	assign stat.shift_done = shift_done;
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = top_addr;
		wr_en       = 1'b0;
		wr_addr     = fill_q[AW-1:0];
		wr_data     = push_value;
		out_load    = 1'b0;
		load_value  = '0;
		load_status = ST_OK;
		load_occ    = fill_q;
		unique case (op)
			DP_PUSH: begin
				wr_en    = 1'b1;
				out_load = 1'b1;
				load_occ = fill_p1;
			end
			DP_REJ_FULL: begin
				out_load    = 1'b1;
				load_status = ST_FULL;
			end
			DP_REJ_EMPTY: begin
				out_load    = 1'b1;
				load_status = ST_EMPTY;
			end
			DP_POP, DP_PEEK, DP_SCAN_START: begin
				rd_en = 1'b1;
			end
			DP_READ_OUT: begin
				out_load   = 1'b1;
				load_value = rd_data_q;
			end
			DP_SCAN: begin
				rd_en   = !stat.scan_last;
				rd_addr = idx_q - AW'(1);
			end
			DP_SHIFT: begin
				wr_en      = pend_q;
				wr_addr    = wptr_q[AW-1:0];
				wr_data    = rd_data_q;
				rd_en      = !shift_done;
				rd_addr    = shift_rd[AW-1:0];
				out_load   = shift_done;
				load_value = min_q;
				load_occ   = fill_m1;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (op == DP_SCAN_START) begin
			idx_q <= top_addr;
		end else if (op == DP_SCAN) begin
			if (scan_take) begin
				min_q <= rd_data_q;
				pos_q <= idx_q;
			end
			idx_q <= idx_q - AW'(1);
			if (stat.scan_last) begin
				wptr_q <= scan_take ? CW'(idx_q) : CW'(pos_q);
			end
		end else if (op == DP_SHIFT) begin
			wptr_q <= wptr_nxt;
		end
		if (out_load) begin
			value_q  <= load_value;
			status_q <= load_status;
			occ_q    <= OCC_W'(load_occ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == DP_PUSH) begin
				fill_q <= fill_p1;
			end else if ((op == DP_POP) || ((op == DP_SHIFT) && shift_done)) begin
				fill_q <= fill_m1;
			end
			if (op == DP_SHIFT) begin
				pend_q <= !shift_done;
			end else begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_value     = value_q;
	assign out_status    = status_q;
	assign out_occupancy = occ_q;
endmodule

// ===== design/stack_with_remove_min.sv =====
// Top level of the stack of signed keys with push, pop, peek and remove-minimum.
// The block takes one command word at a time and answers each with one result word.
// Push and the refused commands (push on a full stack, anything else on an empty one)
// load the result register as soon as they are accepted; pop and peek first read the
// key into the registered read port of the key memory and load it in the read state.
// Remove-minimum starts a read of the top key, scans the memory from the top down for
// the smallest of the keys held, then moves each key above it down one slot and
// loads the minimum as its result, all through the single read and write port of the key
// memory. A finished result that waits in the result register holds off the next
// command; a result taken in the same cycle lets the next command in. Occupancy reports
// the fill count in five bits.
module stack_with_remove_min #(
	parameter int DEPTH = swrm_pkg::DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	swrm_in_if.sink    req,
	swrm_out_if.source rsp
);
	import swrm_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;
	logic     in_ready;

	swrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	swrm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.push_value    (req.push_value),
		.stat          (stat),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_value     (rsp.value),
		.out_status    (rsp.status),
		.out_occupancy (rsp.occupancy)
	);

	assign req.ready = in_ready;
endmodule
